### design/iml_pkg.sv
package iml_pkg;

  // Table depth of the normal CDF; must be a power of two (64 .. 16384).
  localparam int unsigned CDF_DEPTH = 1024;
  localparam int unsigned CDF_AW    = $clog2(CDF_DEPTH);

  localparam int unsigned PROB_W   = 17;
  localparam int unsigned MEAN_W   = 24;
  localparam int unsigned OBS_W    = 16;
  localparam int unsigned SHIFT_W  = 17;
  localparam int unsigned SUM_W    = 48;
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned CFG_DW   = 24;
  localparam int unsigned TDATA_IW = 88;
  localparam int unsigned TUSER_IW = 2;

  localparam logic [PROB_W-1:0] ONE_Q16 = 17'h10000;
  localparam logic [32:0]       ONE_Q32 = 33'h1_0000_0000;
  localparam logic [31:0]       LN2_Q32 = 32'd2977044472;
  localparam logic [SUM_W-1:0]  SUM_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [SUM_W-1:0]  SUM_MIN = 48'h8000_0000_0000;
  localparam logic [MEAN_W-1:0] MEAN_RST  = 24'd28672;
  localparam logic [MEAN_W-1:0] SIGMA_RST = 24'd3840;

  typedef enum logic [CFG_AW-1:0] {
    CFG_HEALTHY_FRACTION = 3'd0,
    CFG_HEALTHY_MEAN     = 3'd1,
    CFG_HEALTHY_SIGMA    = 3'd2,
    CFG_CANCER_MEAN      = 3'd3,
    CFG_CANCER_SIGMA     = 3'd4,
    CFG_ABSENT_ERROR     = 3'd5,
    CFG_PRESENT_ERROR    = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    GRP_HEALTHY = 2'd0,
    GRP_CANCER  = 2'd1,
    GRP_ALPHA   = 2'd2
  } mix_grp_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PHI_SETUP,
    S_DIV,
    S_ROM,
    S_INTERP,
    S_PHI_END,
    S_MIX_A,
    S_MIX_B,
    S_MIX_C,
    S_TERM_A,
    S_TERM_B,
    S_NORM,
    S_SQR_A,
    S_SQR_B,
    S_LN_MUL,
    S_LN_END,
    S_FIN
  } state_e;

  typedef logic [32:0] cdf_word_t;
  typedef cdf_word_t cdf_rom_t [CDF_DEPTH+1];

  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    int          i;
    r = '0;
    q = '0;
    for (i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-r), r Q0.32 below one, Taylor series
  function automatic logic [63:0] exp_frac(input logic [63:0] r);
    longint      acc;
    logic [63:0] term;
    int          k;
    acc  = 64'sh1_0000_0000;
    term = 64'h1_0000_0000;
    for (k = 1; k <= 24; k++) begin
      term = udiv64((term * r) >> 32, 64'(k));
      if ((k % 2) == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > 64'sh1_0000_0000) acc = 64'sh1_0000_0000;
    return 64'(acc);
  endfunction

  function automatic logic [63:0] gauss_at(input logic [63:0] j, input logic [63:0] e1);
    logic [63:0] dd;
    logic [63:0] num;
    logic [63:0] n;
    logic [63:0] rm;
    logic [63:0] g;
    logic [63:0] i;
    dd  = 64'(CDF_DEPTH) * 64'(CDF_DEPTH);
    num = 64'd8 * j * j;
    n   = udiv64(num, dd);
    rm  = num - n * dd;
    g   = exp_frac(udiv64(rm << 32, dd));
    for (i = 0; i < n; i++) g = (g * e1) >> 32;
    return g;
  endfunction

  // Normal CDF on [0, 8], Simpson integration normalized to 0.5 .. 1.0
  function automatic cdf_rom_t build_cdf_tab();
    logic [63:0] raw [CDF_DEPTH+1];
    cdf_rom_t    tab;
    logic [63:0] h;
    logic [63:0] e1;
    logic [63:0] total;
    logic [63:0] rem;
    logic [63:0] q;
    int          k;
    int          b;
    h  = exp_frac(64'h8000_0000);
    e1 = (h * h) >> 32;
    raw[0] = '0;
    for (k = 0; k < CDF_DEPTH; k++) begin
      raw[k+1] = raw[k] + gauss_at(64'(2 * k), e1) + 64'd4 * gauss_at(64'(2 * k + 1), e1)
               + gauss_at(64'(2 * k + 2), e1);
    end
    total = raw[CDF_DEPTH];
    for (k = 0; k <= CDF_DEPTH; k++) begin
      rem = raw[k];
      q   = '0;
      if (rem >= total) begin
        tab[k] = ONE_Q32;
      end else begin
        for (b = 0; b < 31; b++) begin
          rem = rem << 1;
          q   = q << 1;
          if (rem >= total) begin
            rem  = rem - total;
            q[0] = 1'b1;
          end
        end
        tab[k] = 33'h0_8000_0000 + 33'(q);
      end
    end
    return tab;
  endfunction

  function automatic logic [PROB_W-1:0] clamp_prob(input logic [PROB_W-1:0] p);
    return (p > ONE_Q16) ? ONE_Q16 : p;
  endfunction

endpackage

### design/iml_cdf_rom.sv
module iml_cdf_rom (
  input  logic                    clk_i,
  input  logic [iml_pkg::CDF_AW:0] addr_a_i,
  input  logic [iml_pkg::CDF_AW:0] addr_b_i,
  output iml_pkg::cdf_word_t      data_a_o,
  output iml_pkg::cdf_word_t      data_b_o
);
  import iml_pkg::*;

  localparam cdf_rom_t CdfRom = build_cdf_tab();

  always_ff @(posedge clk_i) begin
    data_a_o <= CdfRom[addr_a_i];
    data_b_o <= CdfRom[addr_b_i];
  end

endmodule

### design/indel_mixture_loglikelihood.sv
// Items are handled one at a time: a new input is taken only in idle, after the last item ends.
// A CDF lookup runs the bit-serial sigma divider, then the ROM read and the interpolation;
// an argument beyond the table skips all three. An insert item needs 4 lookups, 8 from the
// cancer sample. The log normalizes the term by left shifts, then runs 20 squarings. Split items
// skip the lookups. Async reset clears sum, zero flag and pending result, loads defaults.
module indel_mixture_loglikelihood (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // obs_value, valid_prob, healthy_vaf, cancer_vaf, indel_shift, zero pad
  input  logic [iml_pkg::TDATA_IW-1:0]    s_axis_tdata_i,
  // from_cancer, is_split
  input  logic [iml_pkg::TUSER_IW-1:0]    s_axis_tuser_i,
  input  logic                            s_axis_tlast_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // log_likelihood
  output logic [iml_pkg::SUM_W-1:0]       m_axis_tdata_o,
  // zero_term
  output logic                            m_axis_tuser_o,
  input  logic                            cfg_we_i,
  input  logic [iml_pkg::CFG_AW-1:0]      cfg_addr_i,
  input  logic [iml_pkg::CFG_DW-1:0]      cfg_wdata_i
);
  import iml_pkg::*;

  localparam int unsigned POS_W = 19 + CDF_AW;

  state_e state_q, state_d;

  logic [PROB_W-1:0] alpha_q, aerr_q, perr_q;
  logic [MEAN_W-1:0] hmean_q, hsigma_q, cmean_q, csigma_q;

  logic              fc_q, fc_d, split_q, split_d, last_q, last_d;
  logic [OBS_W-1:0]  obs_q, obs_d;
  logic [PROB_W-1:0] vp_q, vp_d, hv_q, hv_d, cv_q, cv_d;
  logic [SHIFT_W-1:0] shift_q, shift_d;

  logic [2:0]  pass_q, pass_d;
  mix_grp_e    grp_q, grp_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d, ovf_q, ovf_d;
  logic [42:0] num_q, num_d;
  logic [41:0] dsh_q, dsh_d;
  logic [18:0] zq_q, zq_d;
  logic [32:0] hi_q, hi_d;
  logic [33:0] dn_q [4];
  logic [33:0] dn_d [4];
  logic [65:0] prod_q;
  logic [49:0] acc_q, acc_d;
  logic [33:0] mh_q, mh_d, mc_q, mc_d, mix_q, mix_d;
  logic [33:0] m_q, m_d;
  logic [5:0]  e_q, e_d;
  logic [31:0] mant_q, mant_d;
  logic [19:0] frac_q, frac_d;
  logic        lneg_q, lneg_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic        zero_q, zero_d;
  logic        out_valid_q, out_valid_d, out_zero_q;
  logic [SUM_W-1:0] out_data_q;
  logic        load_out;

  // datapath nets
  logic [MEAN_W-1:0] mean_sel, sigma_sel, s_eff;
  logic signed [27:0] a_val;
  logic        a_neg, a_ovf, div_ge;
  logic [26:0] a_mag;
  logic [POS_W-1:0] pos;
  logic [CDF_AW:0] rom_addr_a, rom_addr_b;
  cdf_word_t   rom_a, rom_b;
  logic [32:0] rom_diff, v_interp, v_sel, phi;
  logic [33:0] dn_new;
  logic [PROB_W-1:0] ep, ea, alpha, lp, la, w;
  logic [33:0] b0, b1, mix_sel;
  logic [50:0] mix_sum;
  logic [33:0] mix_val;
  logic [34:0] term_sum;
  logic [33:0] term;
  logic [32:0] sq;
  logic [6:0]  e_m;
  logic signed [26:0] l_val;
  logic [25:0] l_mag;
  logic [58:0] ln_round;
  logic signed [23:0] ln_val;
  logic [48:0] sum_ext;
  logic [48:0] sum_sat;
  logic [31:0] mul_a;
  logic [33:0] mul_b;

  iml_cdf_rom u_rom (
    .clk_i    (clk_i),
    .addr_a_i (rom_addr_a),
    .addr_b_i (rom_addr_b),
    .data_a_o (rom_a),
    .data_b_o (rom_b)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q  <= '0;
      hmean_q  <= MEAN_RST;
      hsigma_q <= SIGMA_RST;
      cmean_q  <= MEAN_RST;
      csigma_q <= SIGMA_RST;
      aerr_q   <= '0;
      perr_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_HEALTHY_FRACTION: alpha_q  <= cfg_wdata_i[PROB_W-1:0];
        CFG_HEALTHY_MEAN:     hmean_q  <= cfg_wdata_i;
        CFG_HEALTHY_SIGMA:    hsigma_q <= cfg_wdata_i;
        CFG_CANCER_MEAN:      cmean_q  <= cfg_wdata_i;
        CFG_CANCER_SIGMA:     csigma_q <= cfg_wdata_i;
        CFG_ABSENT_ERROR:     aerr_q   <= cfg_wdata_i[PROB_W-1:0];
        CFG_PRESENT_ERROR:    perr_q   <= cfg_wdata_i[PROB_W-1:0];
        default: ;
      endcase
    end
  end

  // datapath
  always_comb begin
    // pass bit 2: cancer, bit 1: plain mean, bit 0: lower CDF point
    mean_sel  = pass_q[2] ? cmean_q : hmean_q;
    sigma_sel = pass_q[2] ? csigma_q : hsigma_q;
    s_eff     = (sigma_sel == '0) ? 24'd1 : sigma_sel;
    a_val = $signed({4'b0, obs_q, 8'b0}) - $signed({4'b0, mean_sel})
          - (pass_q[1] ? 28'sd0 : $signed({{3{shift_q[16]}}, shift_q, 8'b0}))
          + (pass_q[0] ? 28'sd0 : 28'sd256);
    a_neg = a_val[27];
    a_mag = a_neg ? 27'(-a_val) : a_val[26:0];
    a_ovf = a_mag >= {s_eff, 3'b0};
    div_ge = num_q >= {1'b0, dsh_q};

    pos        = POS_W'(zq_q) * POS_W'(CDF_DEPTH);
    rom_addr_a = {1'b0, pos[POS_W-1:19]};
    rom_addr_b = {1'b0, pos[POS_W-1:19]} + (CDF_AW+1)'(1);
    rom_diff   = rom_b - rom_a;
    v_interp   = rom_a + prod_q[48:16];
    v_sel      = ovf_q ? ONE_Q32 : v_interp;
    phi        = neg_q ? (ONE_Q32 - v_sel) : v_sel;
    dn_new     = (hi_q > phi) ? {hi_q - phi, 1'b0} : '0;

    ep    = clamp_prob(perr_q);
    ea    = clamp_prob(aerr_q);
    alpha = clamp_prob(alpha_q);
    lp    = (obs_q != '0) ? (ONE_Q16 - ep) : ep;
    la    = (obs_q != '0) ? ea : (ONE_Q16 - ea);

    case (grp_q)
      GRP_HEALTHY: begin
        w  = hv_q;
        b0 = split_q ? 34'(lp) : dn_q[0];
        b1 = split_q ? 34'(la) : dn_q[1];
      end
      GRP_CANCER: begin
        w  = cv_q;
        b0 = split_q ? 34'(lp) : dn_q[2];
        b1 = split_q ? 34'(la) : dn_q[3];
      end
      default: begin
        w  = alpha;
        b0 = mh_q;
        b1 = mc_q;
      end
    endcase
    mix_sum = 51'(acc_q) + 51'(prod_q[49:0]);
    mix_val = (split_q && grp_q != GRP_ALPHA) ? mix_sum[33:0] : mix_sum[49:16];
    mix_sel = fc_q ? mix_q : mh_q;

    term_sum = 35'(prod_q[49:16]) + 35'({ONE_Q16 - vp_q, 16'b0});
    term     = term_sum[33:0];

    sq       = prod_q[63:31];
    e_m      = 7'({1'b0, e_q}) - 7'd32;
    l_val    = $signed({e_m, frac_q});
    l_mag    = l_val[26] ? 26'(-l_val) : l_val[25:0];
    ln_round = prod_q[58:0] + (59'(1) << 35);
    ln_val   = lneg_q ? -$signed({1'b0, ln_round[58:36]}) : $signed({1'b0, ln_round[58:36]});
    sum_ext  = {sum_q[47], sum_q} + {{25{ln_val[23]}}, ln_val};
    if (sum_ext[48] != sum_ext[47]) begin
      sum_sat = sum_ext[48] ? {1'b1, SUM_MIN} : {1'b0, SUM_MAX};
    end else begin
      sum_sat = sum_ext;
    end

    // shared multiplier operands
    case (state_q)
      S_INTERP: begin
        mul_a = 32'(pos[18:3]);
        mul_b = 34'(rom_diff);
      end
      S_MIX_A: begin
        mul_a = 32'(w);
        mul_b = b0;
      end
      S_MIX_B: begin
        mul_a = 32'(ONE_Q16 - w);
        mul_b = b1;
      end
      S_TERM_A: begin
        mul_a = 32'(vp_q);
        mul_b = mix_sel;
      end
      S_SQR_A: begin
        mul_a = mant_q;
        mul_b = 34'(mant_q);
      end
      S_LN_MUL: begin
        mul_a = LN2_Q32;
        mul_b = 34'(l_mag);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= 66'(mul_a) * 66'(mul_b);
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    fc_d    = fc_q;
    split_d = split_q;
    last_d  = last_q;
    obs_d   = obs_q;
    vp_d    = vp_q;
    hv_d    = hv_q;
    cv_d    = cv_q;
    shift_d = shift_q;
    pass_d  = pass_q;
    grp_d   = grp_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    ovf_d   = ovf_q;
    num_d   = num_q;
    dsh_d   = dsh_q;
    zq_d    = zq_q;
    hi_d    = hi_q;
    dn_d    = dn_q;
    acc_d   = acc_q;
    mh_d    = mh_q;
    mc_d    = mc_q;
    mix_d   = mix_q;
    m_d     = m_q;
    e_d     = e_q;
    mant_d  = mant_q;
    frac_d  = frac_q;
    lneg_d  = lneg_q;
    sum_d   = sum_q;
    zero_d  = zero_q;
    load_out = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          fc_d    = s_axis_tuser_i[0];
          split_d = s_axis_tuser_i[1];
          last_d  = s_axis_tlast_i;
          obs_d   = s_axis_tdata_i[15:0];
          vp_d    = clamp_prob(s_axis_tdata_i[32:16]);
          hv_d    = clamp_prob(s_axis_tdata_i[49:33]);
          cv_d    = clamp_prob(s_axis_tdata_i[66:50]);
          shift_d = s_axis_tdata_i[83:67];
          pass_d  = '0;
          grp_d   = GRP_HEALTHY;
          state_d = s_axis_tuser_i[1] ? S_MIX_A : S_PHI_SETUP;
        end
      end
      S_PHI_SETUP: begin
        neg_d = a_neg;
        ovf_d = a_ovf;
        num_d = {a_mag, 16'b0};
        dsh_d = {s_eff, 18'b0};
        cnt_d = 5'd18;
        zq_d  = '0;
        state_d = a_ovf ? S_PHI_END : S_DIV;
      end
      S_DIV: begin
        if (div_ge) num_d = num_q - {1'b0, dsh_q};
        zq_d  = {zq_q[17:0], div_ge};
        dsh_d = dsh_q >> 1;
        if (cnt_q == '0) state_d = S_ROM;
        else cnt_d = cnt_q - 5'd1;
      end
      S_ROM:    state_d = S_INTERP;
      S_INTERP: state_d = S_PHI_END;
      S_PHI_END: begin
        if (!pass_q[0]) begin
          hi_d    = phi;
          pass_d  = pass_q + 3'd1;
          state_d = S_PHI_SETUP;
        end else begin
          dn_d[pass_q[2:1]] = dn_new;
          if ((pass_q == 3'd3 && !fc_q) || pass_q == 3'd7) begin
            grp_d   = GRP_HEALTHY;
            state_d = S_MIX_A;
          end else begin
            pass_d  = pass_q + 3'd1;
            state_d = S_PHI_SETUP;
          end
        end
      end
      S_MIX_A: state_d = S_MIX_B;
      S_MIX_B: begin
        acc_d   = prod_q[49:0];
        state_d = S_MIX_C;
      end
      S_MIX_C: begin
        case (grp_q)
          GRP_HEALTHY: begin
            mh_d = mix_val;
            if (fc_q) begin
              grp_d   = GRP_CANCER;
              state_d = S_MIX_A;
            end else begin
              state_d = S_TERM_A;
            end
          end
          GRP_CANCER: begin
            mc_d    = mix_val;
            grp_d   = GRP_ALPHA;
            state_d = S_MIX_A;
          end
          default: begin
            mix_d   = mix_val;
            state_d = S_TERM_A;
          end
        endcase
      end
      S_TERM_A: state_d = S_TERM_B;
      S_TERM_B: begin
        if (zero_q || term == '0) begin
          zero_d  = 1'b1;
          sum_d   = SUM_MIN;
          state_d = S_FIN;
        end else begin
          m_d     = term;
          e_d     = 6'd33;
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        if (m_q[33]) begin
          mant_d  = m_q[33:2];
          frac_d  = '0;
          cnt_d   = 5'd19;
          state_d = S_SQR_A;
        end else begin
          m_d = m_q << 1;
          e_d = e_q - 6'd1;
        end
      end
      S_SQR_A: state_d = S_SQR_B;
      S_SQR_B: begin
        mant_d = sq[32] ? sq[32:1] : sq[31:0];
        frac_d = {frac_q[18:0], sq[32]};
        if (cnt_q == '0) begin
          state_d = S_LN_MUL;
        end else begin
          cnt_d   = cnt_q - 5'd1;
          state_d = S_SQR_A;
        end
      end
      S_LN_MUL: begin
        lneg_d  = l_val[26];
        state_d = S_LN_END;
      end
      S_LN_END: begin
        sum_d   = sum_sat[47:0];
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (!out_valid_q || m_axis_tready_i) begin
          // hand the set result to the output register and start a new set
          load_out = 1'b1;
          sum_d    = '0;
          zero_d   = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = load_out | (out_valid_q & ~m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q       <= '0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      zero_q      <= zero_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fc_q    <= fc_d;
    split_q <= split_d;
    last_q  <= last_d;
    obs_q   <= obs_d;
    vp_q    <= vp_d;
    hv_q    <= hv_d;
    cv_q    <= cv_d;
    shift_q <= shift_d;
    pass_q  <= pass_d;
    grp_q   <= grp_d;
    cnt_q   <= cnt_d;
    neg_q   <= neg_d;
    ovf_q   <= ovf_d;
    num_q   <= num_d;
    dsh_q   <= dsh_d;
    zq_q    <= zq_d;
    hi_q    <= hi_d;
    dn_q    <= dn_d;
    acc_q   <= acc_d;
    mh_q    <= mh_d;
    mc_q    <= mc_d;
    mix_q   <= mix_d;
    m_q     <= m_d;
    e_q     <= e_d;
    mant_q  <= mant_d;
    frac_q  <= frac_d;
    lneg_q  <= lneg_d;
    if (load_out) begin
      out_data_q <= sum_q;
      out_zero_q <= zero_q;
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_zero_q;

`ifndef ASSERT_OFF
  a_zero_pins_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    zero_q |-> (sum_q == SUM_MIN))
    else $error("zero flag set while sum is not at minimum");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_d && !out_valid_q) |-> (state_q == S_FIN && last_q))
    else $error("result raised outside end of set");

  a_sqr_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SQR_B) |=> (state_q == S_SQR_A || state_q == S_LN_MUL))
    else $error("log squaring loop left early");

  a_norm_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_NORM) |-> (m_q != '0))
    else $error("normalizing a zero term");
`endif

endmodule

### bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import iml_pkg::*;

  localparam longint unsigned Q16 = 64'd65536;
  localparam longint unsigned Q32 = 64'h1_0000_0000;
  localparam longint SUM_HI = 64'sd140737488355327;
  localparam longint SUM_LO = -64'sd140737488355328;
  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES = 2000;
  localparam int STALL_LIMIT = 20000;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct {
    logic        from_cancer;
    logic        is_split;
    logic [15:0] obs_value;
    logic [16:0] valid_prob;
    logic [16:0] healthy_vaf;
    logic [16:0] cancer_vaf;
    logic [16:0] indel_shift;
    logic        last_obs;
  } read_obs_t;

  typedef struct {
    logic [47:0] log_lik;
    logic        zero_term;
  } set_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [TDATA_IW-1:0] s_axis_tdata_i = '0;
  logic [TUSER_IW-1:0] s_axis_tuser_i = '0;
  logic s_axis_tlast_i = 1'b0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [SUM_W-1:0] m_axis_tdata_o;
  logic m_axis_tuser_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_AW-1:0] cfg_addr_i = '0;
  logic [CFG_DW-1:0] cfg_wdata_i = '0;

  always #5 clk_i = ~clk_i;

  indel_mixture_loglikelihood i_dut (.*);

  read_obs_t   obs_queue[$];
  read_obs_t   cur_obs;
  set_result_t likelihood_q[$];
  longint unsigned normal_rom[CDF_DEPTH+1];
  logic [23:0] reg_model[7];
  longint      sum_acc;
  logic        zero_acc;
  idle_mode_e  idle_mode = IDLE_NONE;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_cnt = 0;
  int          mismatches = 0;
  int          obs_sent = 0;
  int          sets_checked = 0;
  int          zero_sets = 0;
  int          quiet_cycles = 0;

  // ---------------- predictor ----------------
  function automatic longint unsigned clamp_q16(longint unsigned p);
    return p > Q16 ? Q16 : p;
  endfunction

  function automatic longint unsigned exp_neg(longint unsigned r);
    longint acc;
    longint unsigned term;
    acc = longint'(Q32);
    term = Q32;
    for (int k = 1; k <= 24; k++) begin
      term = ((term * r) >> 32) / longint'(k);
      if (k % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > longint'(Q32)) acc = longint'(Q32);
    return longint'(acc);
  endfunction

  function automatic longint unsigned gauss_sample(longint unsigned j, longint unsigned e1);
    longint unsigned dd, num, n, r, g;
    dd = longint'(CDF_DEPTH) * longint'(CDF_DEPTH);
    num = 8 * j * j;
    n = num / dd;
    r = ((num % dd) << 32) / dd;
    g = exp_neg(r);
    for (longint unsigned i = 0; i < n; i++) g = (g * e1) >> 32;
    return g;
  endfunction

  task automatic build_normal_rom();
    longint unsigned h, e1, total, rem, q;
    h = exp_neg(Q32 >> 1);
    e1 = (h * h) >> 32;
    normal_rom[0] = 0;
    for (int k = 0; k < CDF_DEPTH; k++)
      normal_rom[k+1] = normal_rom[k] + gauss_sample(2*k, e1)
                      + 4 * gauss_sample(2*k + 1, e1) + gauss_sample(2*k + 2, e1);
    total = normal_rom[CDF_DEPTH];
    for (int k = 0; k <= CDF_DEPTH; k++) begin
      rem = normal_rom[k];
      q = 0;
      if (rem >= total) begin
        normal_rom[k] = Q32;
      end else begin
        for (int b = 0; b < 31; b++) begin
          rem = rem << 1;
          q = q << 1;
          if (rem >= total) begin
            rem -= total;
            q |= 1;
          end
        end
        normal_rom[k] = (Q32 >> 1) + q;
      end
    end
  endtask

  function automatic longint unsigned phi_lookup(longint a, longint unsigned s);
    longint unsigned mag, zq, pos, k, v, fr;
    mag = a < 0 ? longint'(-a) : longint'(a);
    zq = (mag << 16) / s;
    if (zq > 64'd524288) zq = 64'd524288;
    pos = zq * longint'(CDF_DEPTH);
    k = pos >> 19;
    if (k >= longint'(CDF_DEPTH)) begin
      v = Q32;
    end else begin
      fr = (pos >> 3) & 64'hFFFF;
      v = normal_rom[k] + (((normal_rom[k+1] - normal_rom[k]) * fr) >> 16);
    end
    return a < 0 ? Q32 - v : v;
  endfunction

  function automatic longint unsigned insert_density(longint x, longint m, longint unsigned sreg);
    longint unsigned s, hi, lo;
    s = sreg != 0 ? sreg : 1;
    hi = phi_lookup(x - m + 256, s);
    lo = phi_lookup(x - m, s);
    return hi > lo ? 2 * (hi - lo) : 0;
  endfunction

  function automatic longint ln_fixed(longint unsigned v);
    int e;
    longint unsigned m, fr, mag, res;
    longint l;
    e = 0;
    fr = 0;
    while (e < 63 && (v >> (e + 1)) != 0) e++;
    m = e >= 31 ? v >> (e - 31) : v << (31 - e);
    for (int i = 0; i < 20; i++) begin
      m = (m * m) >> 31;
      fr = fr << 1;
      if (m >= Q32) begin
        m = m >> 1;
        fr |= 1;
      end
    end
    l = longint'(e - 32) * 1048576 + longint'(fr);
    mag = l < 0 ? longint'(-l) : longint'(l);
    res = (mag * 64'd2977044472 + (64'd1 << 35)) >> 36;
    return l < 0 ? -longint'(res) : longint'(res);
  endfunction

  task automatic accumulate_obs(read_obs_t o);
    longint unsigned vp, hv, cv, alpha, ep, ea, lp, la, mh, mc, mix, term;
    longint x, sh, hm, cm, s;
    set_result_t r;
    vp = clamp_q16(o.valid_prob);
    hv = clamp_q16(o.healthy_vaf);
    cv = clamp_q16(o.cancer_vaf);
    alpha = clamp_q16(reg_model[CFG_HEALTHY_FRACTION]);
    mc = 0;
    if (o.is_split) begin
      ep = clamp_q16(reg_model[CFG_PRESENT_ERROR]);
      ea = clamp_q16(reg_model[CFG_ABSENT_ERROR]);
      lp = o.obs_value != 0 ? Q16 - ep : ep;
      la = o.obs_value != 0 ? ea : Q16 - ea;
      mh = hv * lp + (Q16 - hv) * la;
      if (o.from_cancer) mc = cv * lp + (Q16 - cv) * la;
    end else begin
      x = longint'(o.obs_value) * 256;
      sh = longint'($signed(o.indel_shift)) * 256;
      hm = longint'(reg_model[CFG_HEALTHY_MEAN]);
      cm = longint'(reg_model[CFG_CANCER_MEAN]);
      mh = (hv * insert_density(x, hm + sh, reg_model[CFG_HEALTHY_SIGMA])
           + (Q16 - hv) * insert_density(x, hm, reg_model[CFG_HEALTHY_SIGMA])) >> 16;
      if (o.from_cancer)
        mc = (cv * insert_density(x, cm + sh, reg_model[CFG_CANCER_SIGMA])
             + (Q16 - cv) * insert_density(x, cm, reg_model[CFG_CANCER_SIGMA])) >> 16;
    end
    mix = o.from_cancer ? (alpha * mh + (Q16 - alpha) * mc) >> 16 : mh;
    term = ((vp * mix) >> 16) + ((Q16 - vp) << 16);
    if (zero_acc || term == 0) begin
      zero_acc = 1'b1;
      sum_acc = SUM_LO;
    end else begin
      s = sum_acc + ln_fixed(term);
      if (s > SUM_HI) s = SUM_HI;
      if (s < SUM_LO) s = SUM_LO;
      sum_acc = s;
    end
    if (o.last_obs) begin
      r.log_lik = sum_acc[47:0];
      r.zero_term = zero_acc;
      likelihood_q.push_back(r);
      sum_acc = 0;
      zero_acc = 1'b0;
    end
  endtask

  // ---------------- driver ----------------
  function automatic int send_idle_pct();
    return idle_mode == IDLE_SEND ? 76 : idle_mode == IDLE_BOTH ? 33 : 0;
  endfunction

  function automatic int recv_idle_pct();
    return idle_mode == IDLE_RECV ? 76 : idle_mode == IDLE_BOTH ? 33 : 0;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        accumulate_obs(cur_obs);
        obs_sent++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (obs_queue.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
          cur_obs <= obs_queue[0];
          s_axis_tdata_i <= {5'b0, obs_queue[0].indel_shift, obs_queue[0].cancer_vaf,
                             obs_queue[0].healthy_vaf, obs_queue[0].valid_prob,
                             obs_queue[0].obs_value};
          s_axis_tuser_i <= {obs_queue[0].is_split, obs_queue[0].from_cancer};
          s_axis_tlast_i <= obs_queue[0].last_obs;
          s_axis_tvalid_i <= 1'b1;
          obs_queue.pop_front();
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------- receiver ----------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_req && !hold_done) begin
        hold_done <= 1'b1;
        hold_cnt <= HOLD_CYCLES;
        m_axis_tready_i <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= $urandom_range(99) >= recv_idle_pct();
      end
    end
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    set_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (likelihood_q.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata_o, 0);
      end else begin
        want = likelihood_q.pop_front();
        sets_checked++;
        if (want.zero_term) zero_sets++;
        if (m_axis_tdata_o !== want.log_lik)
          report_mismatch("log_likelihood", m_axis_tdata_o, want.log_lik);
        if (m_axis_tuser_o !== want.zero_term)
          report_mismatch("zero_term", m_axis_tuser_o, want.zero_term);
      end
    end
  end

  // drop the run if nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)
        || cfg_we_i || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("** indel_mixture_loglikelihood: FAILED **");
      $finish;
    end
  end

  // ---------------- sequence ----------------
  task automatic push_obs(logic fc, logic sp, int unsigned obs, int unsigned vp,
                          int unsigned hv, int unsigned cv, int sh, logic last);
    read_obs_t o;
    o.from_cancer = fc;
    o.is_split = sp;
    o.obs_value = obs[15:0];
    o.valid_prob = vp[16:0];
    o.healthy_vaf = hv[16:0];
    o.cancer_vaf = cv[16:0];
    o.indel_shift = sh[16:0];
    o.last_obs = last;
    obs_queue.push_back(o);
  endtask

  function automatic int unsigned rand_prob();
    case ($urandom_range(9))
      0: return 0;
      1: return 65536;
      2: return $urandom_range(65537, 131071);
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  task automatic add_sets(int n_sets);
    int len, m, sd, obs, sh;
    int unsigned hv, cv;
    logic fc, sp;
    for (int s = 0; s < n_sets; s++) begin
      len = $urandom_range(1, 7);
      hv = rand_prob();
      cv = rand_prob();
      for (int i = 0; i < len; i++) begin
        fc = 1'($urandom_range(1));
        sp = $urandom_range(99) < 30;
        if ($urandom_range(99) < 10) begin
          push_obs(fc, sp, $urandom_range(65535), $urandom_range(131071), hv, cv,
                   int'($urandom_range(131071)), i == len - 1);
        end else begin
          if (sp) begin
            obs = $urandom_range(9) == 0 ? $urandom_range(65535) : $urandom_range(1);
          end else begin
            m = fc ? int'(reg_model[CFG_CANCER_MEAN] >> 8)
                   : int'(reg_model[CFG_HEALTHY_MEAN] >> 8);
            sd = (fc ? int'(reg_model[CFG_CANCER_SIGMA] >> 8)
                     : int'(reg_model[CFG_HEALTHY_SIGMA] >> 8)) + 1;
            obs = m + int'($urandom_range(0, 8 * sd)) - 4 * sd;
            if (obs < 0) obs = 0;
            if (obs > 65535) obs = 65535;
          end
          sh = int'($urandom_range(0, 40)) - 20;
          push_obs(fc, sp, obs, $urandom_range(0, 65536), hv, cv, sh, i == len - 1);
        end
      end
    end
  endtask

  task automatic wait_drained();
    while (obs_queue.size() > 0 || s_axis_tvalid_i || likelihood_q.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val[23:0];
    if (idx == CFG_HEALTHY_FRACTION || idx == CFG_ABSENT_ERROR || idx == CFG_PRESENT_ERROR)
      reg_model[idx] = {7'b0, val[16:0]};
    else
      reg_model[idx] = val[23:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_regs(int unsigned alpha, int unsigned hm, int unsigned hs,
                           int unsigned cm, int unsigned cs, int unsigned ea,
                           int unsigned ep);
    write_reg(CFG_HEALTHY_FRACTION, alpha);
    write_reg(CFG_HEALTHY_MEAN, hm);
    write_reg(CFG_HEALTHY_SIGMA, hs);
    write_reg(CFG_CANCER_MEAN, cm);
    write_reg(CFG_CANCER_SIGMA, cs);
    write_reg(CFG_ABSENT_ERROR, ea);
    write_reg(CFG_PRESENT_ERROR, ep);
  endtask

  initial begin
    reg_model[CFG_HEALTHY_FRACTION] = 0;
    reg_model[CFG_HEALTHY_MEAN] = MEAN_RST;
    reg_model[CFG_HEALTHY_SIGMA] = SIGMA_RST;
    reg_model[CFG_CANCER_MEAN] = MEAN_RST;
    reg_model[CFG_CANCER_SIGMA] = SIGMA_RST;
    reg_model[CFG_ABSENT_ERROR] = 0;
    reg_model[CFG_PRESENT_ERROR] = 0;
    sum_acc = 0;
    zero_acc = 1'b0;
    build_normal_rom();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pass on reset defaults
    push_obs(0, 0, 112, 65536, 0, 0, 0, 1);
    push_obs(1, 0, 112, 65536, 65536, 65536, 5, 0);
    push_obs(0, 0, 0, 65536, 32768, 0, -65535, 0);
    push_obs(1, 0, 120, 131071, 131071, 131071, 65535, 1);
    push_obs(0, 1, 1, 65536, 65536, 0, 0, 0);
    push_obs(0, 1, 0, 65536, 0, 0, 0, 0);
    push_obs(1, 1, 2, 40000, 20000, 65536, 0, 0);
    push_obs(1, 1, 65535, 0, 65536, 0, 0, 1);
    push_obs(0, 0, 65535, 0, 0, 0, 0, 1);
    // zero term mid-set, later items must not lift the sum
    push_obs(0, 0, 110, 30000, 0, 0, 0, 0);
    push_obs(0, 0, 65535, 65536, 0, 0, 0, 0);
    push_obs(1, 0, 112, 65536, 0, 0, 0, 0);
    push_obs(0, 1, 0, 65536, 0, 0, 0, 1);
    push_obs(1, 0, 100, 65536, 65536, 0, 12, 0);
    push_obs(1, 0, 124, 65536, 0, 65536, -12, 1);
    wait_drained();

    idle_mode = IDLE_NONE;
    hold_req = 1'b1;
    add_sets(70);
    wait_drained();

    load_regs(32768, 30000, 2000, 40000, 6000, 655, 1310);
    idle_mode = IDLE_SEND;
    add_sets(70);
    wait_drained();

    load_regs(131071, 0, 0, 0, 0, 65536, 131071);
    idle_mode = IDLE_RECV;
    add_sets(70);
    wait_drained();

    load_regs(0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 65536);
    idle_mode = IDLE_BOTH;
    add_sets(70);
    wait_drained();

    load_regs(65536, 28672, 1, 28672, 1, 100, 50);
    idle_mode = IDLE_NONE;
    add_sets(60);
    wait_drained();

    load_regs($urandom_range(131071), $urandom_range(20000, 60000), $urandom_range(256, 8000),
              $urandom_range(20000, 60000), $urandom_range(256, 8000),
              $urandom_range(131071), $urandom_range(131071));
    idle_mode = IDLE_BOTH;
    add_sets(70);
    wait_drained();

    $display("covered %0d observations in %0d sets (%0d with a zero term)",
             obs_sent, sets_checked, zero_sets);
    $display("six register settings, idle and stall mixes, one long receiver hold-off");
    if (mismatches == 0 && likelihood_q.size() == 0) begin
      $display("** indel_mixture_loglikelihood: PASSED **");
    end else begin
      $display("** indel_mixture_loglikelihood: FAILED **");
    end
    $finish;
  end

endmodule
